// ----- sv/tfn_pkg.sv -----
`timescale 1ns / 1ps
package tfn_pkg;

   localparam int FIELD_W = 16;
   localparam int MINLEN_W = 16;
   localparam int LANES = 3;

endpackage

// ----- sv/triangle_face_normal.sv -----
`timescale 1ns / 1ps
// Unit face normal of a triangle given by three vertices A, B and C.
// Input channel: an item (nine signed coordinates on the req_ ports) is taken
// at a rising edge where start is high and busy is low. busy is low at all
// times outside reset, so one item may be started in every cycle.
// Result channel: rsp_valid is high for exactly one cycle with the normal
// components in Q1.NORMAL_FRAC_BITS and the degenerate flag; the receiver
// must take it in that cycle, since results cannot be held off.
// Configuration: csr_data is written to the minimum length register when
// csr_valid and csr_ready are both high; write it only while no item is in
// flight.
// The path from start to rsp_valid runs through the edge, cross product,
// sign and magnitude, partial product, square and sum registers, one cell
// per root bit in the square root cell row, the compare register, one cell
// per fraction bit in the divider cell row and the output register.
// Throughput is one item per cycle.
// Reset clears all valid flags and the minimum length; items in flight are
// dropped.
module triangle_face_normal
   import tfn_pkg::*;
#(
   parameter int COORD_WIDTH = 16,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [COORD_WIDTH-1:0] req_ax,
   input  logic [COORD_WIDTH-1:0] req_ay,
   input  logic [COORD_WIDTH-1:0] req_az,
   input  logic [COORD_WIDTH-1:0] req_bx,
   input  logic [COORD_WIDTH-1:0] req_by_coord,
   input  logic [COORD_WIDTH-1:0] req_bz,
   input  logic [COORD_WIDTH-1:0] req_cx,
   input  logic [COORD_WIDTH-1:0] req_cy,
   input  logic [COORD_WIDTH-1:0] req_cz,
   output logic                   rsp_valid,
   output logic [FIELD_W-1:0]     rsp_norm_x,
   output logic [FIELD_W-1:0]     rsp_norm_y,
   output logic [FIELD_W-1:0]     rsp_norm_z,
   output logic                   rsp_degenerate,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [MINLEN_W-1:0]    csr_data
);

   localparam int CW = COORD_WIDTH;
   localparam int FB = NORMAL_FRAC_BITS;
   localparam int EW = CW + 1;
   localparam int PW = 2 * EW;
   localparam int NW = PW + 1;
   localparam int MW = NW;
   localparam int RW = NW;
   localparam int SW = 2 * RW;
   localparam int HL = (MW + 1) / 2;
   localparam int HH = MW - HL;
   localparam int SQ_PAYW = LANES * MW + LANES;
   localparam int DV_PAYW = 2 * LANES + 1;
   localparam int XW = (FB + 1 > FIELD_W) ? FB + 1 : FIELD_W;

   logic [MINLEN_W-1:0] min_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         min_length_ff <= csr_data;
      end
   end

   assign busy      = reset;
   assign csr_ready = !reset;

   // Edges.
   logic                    v1_ff;
   logic signed [EW-1:0]    e1x_ff, e1y_ff, e1z_ff, e2x_ff, e2y_ff, e2z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
      end
      e1x_ff <= EW'(signed'(req_bx)) - EW'(signed'(req_ax));
      e1y_ff <= EW'(signed'(req_by_coord)) - EW'(signed'(req_ay));
      e1z_ff <= EW'(signed'(req_bz)) - EW'(signed'(req_az));
      e2x_ff <= EW'(signed'(req_cx)) - EW'(signed'(req_ax));
      e2y_ff <= EW'(signed'(req_cy)) - EW'(signed'(req_ay));
      e2z_ff <= EW'(signed'(req_cz)) - EW'(signed'(req_az));
   end

   // Cross product terms.
   logic                 v2_ff;
   logic signed [PW-1:0] p_ff [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      p_ff[0] <= PW'(e1y_ff) * PW'(e2z_ff);
      p_ff[1] <= PW'(e1z_ff) * PW'(e2y_ff);
      p_ff[2] <= PW'(e1z_ff) * PW'(e2x_ff);
      p_ff[3] <= PW'(e1x_ff) * PW'(e2z_ff);
      p_ff[4] <= PW'(e1x_ff) * PW'(e2y_ff);
      p_ff[5] <= PW'(e1y_ff) * PW'(e2x_ff);
   end

   // Cross product as sign and magnitude.
   logic                      v3_ff;
   logic [LANES-1:0]          sign3_ff;
   logic [LANES-1:0][MW-1:0]  mag3_ff;
   logic signed [NW-1:0]      n_diff [LANES];

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         n_diff[k] = NW'(p_ff[2 * k]) - NW'(p_ff[2 * k + 1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      for (int k = 0; k < LANES; k++) begin
         sign3_ff[k] <= n_diff[k][NW-1];
         mag3_ff[k]  <= n_diff[k][NW-1] ? MW'(-n_diff[k]) : MW'(n_diff[k]);
      end
   end

   // Squares from split partial products.
   logic                     v4_ff, v5_ff, v6_ff;
   logic [SQ_PAYW-1:0]       pay4_ff, pay5_ff, pay6_ff;
   logic [2*HH-1:0]          phh_ff [LANES];
   logic [HH+HL-1:0]         phl_ff [LANES];
   logic [2*HL-1:0]          pll_ff [LANES];
   logic [SW-1:0]            sq5_ff [LANES];
   logic [SW-1:0]            sum6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
      pay4_ff <= {sign3_ff, mag3_ff};
      pay5_ff <= pay4_ff;
      pay6_ff <= pay5_ff;
      for (int k = 0; k < LANES; k++) begin
         phh_ff[k] <= (2*HH)'(mag3_ff[k][MW-1:HL]) * (2*HH)'(mag3_ff[k][MW-1:HL]);
         phl_ff[k] <= (HH+HL)'(mag3_ff[k][MW-1:HL]) * (HH+HL)'(mag3_ff[k][HL-1:0]);
         pll_ff[k] <= (2*HL)'(mag3_ff[k][HL-1:0]) * (2*HL)'(mag3_ff[k][HL-1:0]);
         sq5_ff[k] <= (SW'(phh_ff[k]) << (2 * HL)) + (SW'(phl_ff[k]) << (HL + 1))
                      + SW'(pll_ff[k]);
      end
      sum6_ff <= sq5_ff[0] + sq5_ff[1] + sq5_ff[2];
   end

   // Square root cell row, one root bit per cell.
   logic [RW:0]              sq_valid;
   logic [RW:0][SW-1:0]      sq_rem;
   logic [RW:0][SW-1:0]      sq_root;
   logic [RW:0][SQ_PAYW-1:0] sq_pay;

   assign sq_valid[0] = v6_ff;
   assign sq_rem[0]   = sum6_ff;
   assign sq_root[0]  = '0;
   assign sq_pay[0]   = pay6_ff;

   for (genvar g = 0; g < RW; g++) begin : g_sqrt
      tfn_sqrt_cell #(
         .SW(SW),
         .BIT_POS(RW - 1 - g),
         .PAYW(SQ_PAYW)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .up_valid(sq_valid[g]),
         .up_rem(sq_rem[g]),
         .up_root(sq_root[g]),
         .up_payload(sq_pay[g]),
         .dn_valid(sq_valid[g+1]),
         .dn_rem(sq_rem[g+1]),
         .dn_root(sq_root[g+1]),
         .dn_payload(sq_pay[g+1])
      );
   end

   // Threshold compare and divider setup.
   logic [RW-1:0]             len_w;
   logic [LANES-1:0]          sign_w;
   logic [LANES-1:0][MW-1:0]  mag_w;
   logic                      v7_ff;
   logic [RW-1:0]             len7_ff;
   logic [LANES-1:0][RW-1:0]  rem7_ff;
   logic [DV_PAYW-1:0]        pay7_ff;
   logic [LANES-1:0]          full_in;

   assign len_w  = sq_root[RW][RW-1:0];
   assign sign_w = sq_pay[RW][SQ_PAYW-1:LANES*MW];
   assign mag_w  = sq_pay[RW][LANES*MW-1:0];

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         full_in[k] = mag_w[k] >= len_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else begin
         v7_ff <= sq_valid[RW];
      end
      len7_ff <= len_w;
      for (int k = 0; k < LANES; k++) begin
         rem7_ff[k] <= full_in[k] ? '0 : mag_w[k];
      end
      pay7_ff <= {!(len_w > RW'(min_length_ff)), full_in, sign_w};
   end

   // Divider cell row, one fraction bit per cell.
   logic [FB:0]                        dv_valid;
   logic [FB:0][RW-1:0]                dv_len;
   logic [FB:0][LANES-1:0][RW-1:0]     dv_rem;
   logic [FB:0][LANES-1:0][FB-1:0]     dv_quot;
   logic [FB:0][DV_PAYW-1:0]           dv_pay;

   assign dv_valid[0] = v7_ff;
   assign dv_len[0]   = len7_ff;
   assign dv_rem[0]   = rem7_ff;
   assign dv_quot[0]  = '0;
   assign dv_pay[0]   = pay7_ff;

   for (genvar g = 0; g < FB; g++) begin : g_div
      tfn_div_cell #(
         .RW(RW),
         .QW(FB),
         .PAYW(DV_PAYW)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .up_valid(dv_valid[g]),
         .up_len(dv_len[g]),
         .up_rem(dv_rem[g]),
         .up_quot(dv_quot[g]),
         .up_payload(dv_pay[g]),
         .dn_valid(dv_valid[g+1]),
         .dn_len(dv_len[g+1]),
         .dn_rem(dv_rem[g+1]),
         .dn_quot(dv_quot[g+1]),
         .dn_payload(dv_pay[g+1])
      );
   end

   // Output register.
   logic                           out_valid_ff;
   logic [LANES-1:0][FIELD_W-1:0]  norm_ff, norm_in;
   logic                           degen_ff;
   logic                           degen_w;
   logic [LANES-1:0]               full_w;
   logic [LANES-1:0]               sgn_w;
   logic [XW-1:0]                  qx;
   logic [XW-1:0]                  sval;

   assign degen_w = dv_pay[FB][2*LANES];
   assign full_w  = dv_pay[FB][2*LANES-1:LANES];
   assign sgn_w   = dv_pay[FB][LANES-1:0];

   always_comb begin
      qx   = '0;
      sval = '0;
      for (int k = 0; k < LANES; k++) begin
         qx   = full_w[k] ? (XW'(1) << FB) : XW'(dv_quot[FB][k]);
         sval = sgn_w[k] ? -qx : qx;
         norm_in[k] = degen_w ? '0 : sval[FIELD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= dv_valid[FB];
      end
      norm_ff  <= norm_in;
      degen_ff <= degen_w;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_norm_x     = norm_ff[0];
   assign rsp_norm_y     = norm_ff[1];
   assign rsp_norm_z     = norm_ff[2];
   assign rsp_degenerate = degen_ff;

endmodule

// ----- sv/tfn_sqrt_cell.sv -----
`timescale 1ns / 1ps
module tfn_sqrt_cell
   import tfn_pkg::*;
#(
   parameter int SW = 70,
   parameter int BIT_POS = 34,
   parameter int PAYW = 108
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            up_valid,
   input  logic [SW-1:0]   up_rem,
   input  logic [SW-1:0]   up_root,
   input  logic [PAYW-1:0] up_payload,
   output logic            dn_valid,
   output logic [SW-1:0]   dn_rem,
   output logic [SW-1:0]   dn_root,
   output logic [PAYW-1:0] dn_payload
);

   localparam logic [SW-1:0] BIT_VAL = SW'(1) << (2 * BIT_POS);

   logic            valid_ff;
   logic [SW-1:0]   rem_ff, rem_in;
   logic [SW-1:0]   root_ff, root_in;
   logic [PAYW-1:0] payload_ff;
   logic [SW-1:0]   trial;

   always_comb begin
      trial = up_root + BIT_VAL;
      if (up_rem >= trial) begin
         rem_in  = up_rem - trial;
         root_in = (up_root >> 1) + BIT_VAL;
      end else begin
         rem_in  = up_rem;
         root_in = up_root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      payload_ff <= up_payload;
   end

   assign dn_valid   = valid_ff;
   assign dn_rem     = rem_ff;
   assign dn_root    = root_ff;
   assign dn_payload = payload_ff;

endmodule

// ----- sv/tfn_div_cell.sv -----
`timescale 1ns / 1ps
module tfn_div_cell
   import tfn_pkg::*;
#(
   parameter int RW = 35,
   parameter int QW = 14,
   parameter int PAYW = 7
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       up_valid,
   input  logic [RW-1:0]              up_len,
   input  logic [LANES-1:0][RW-1:0]   up_rem,
   input  logic [LANES-1:0][QW-1:0]   up_quot,
   input  logic [PAYW-1:0]            up_payload,
   output logic                       dn_valid,
   output logic [RW-1:0]              dn_len,
   output logic [LANES-1:0][RW-1:0]   dn_rem,
   output logic [LANES-1:0][QW-1:0]   dn_quot,
   output logic [PAYW-1:0]            dn_payload
);

   logic                     valid_ff;
   logic [RW-1:0]            len_ff;
   logic [LANES-1:0][RW-1:0] rem_ff, rem_in;
   logic [LANES-1:0][QW-1:0] quot_ff, quot_in;
   logic [PAYW-1:0]          payload_ff;
   logic [RW:0]              shifted;

   always_comb begin
      shifted = '0;
      for (int k = 0; k < LANES; k++) begin
         shifted = {up_rem[k], 1'b0};
         if (shifted >= {1'b0, up_len}) begin
            rem_in[k]  = RW'(shifted - {1'b0, up_len});
            quot_in[k] = {up_quot[k][QW-2:0], 1'b1};
         end else begin
            rem_in[k]  = shifted[RW-1:0];
            quot_in[k] = {up_quot[k][QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
      len_ff     <= up_len;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      payload_ff <= up_payload;
   end

   assign dn_valid   = valid_ff;
   assign dn_len     = len_ff;
   assign dn_rem     = rem_ff;
   assign dn_quot    = quot_ff;
   assign dn_payload = payload_ff;

endmodule

// ----- sv/tfn_checker.sv -----
`timescale 1ns / 1ps
module tfn_checker
   import tfn_pkg::*;
#(
   parameter int COORD_WIDTH = 16,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [FIELD_W-1:0] rsp_norm_x,
   input logic [FIELD_W-1:0] rsp_norm_y,
   input logic [FIELD_W-1:0] rsp_norm_z,
   input logic               rsp_degenerate,
   input logic               csr_ready
);

   localparam int LATENCY = 8 + 2 * COORD_WIDTH + 3 + NORMAL_FRAC_BITS;

   a_no_busy: assert property (@(posedge clock) disable iff (reset)
      !busy && csr_ready)
      else $error("block reported busy outside reset");

   a_issue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without a matching item");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_norm_x == '0 && rsp_norm_y == '0 && rsp_norm_z == '0)
      else $error("degenerate result with nonzero normal");

   a_normal_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |->
         rsp_norm_x != '0 || rsp_norm_y != '0 || rsp_norm_z != '0)
      else $error("normalized result is a zero vector");

endmodule

bind triangle_face_normal tfn_checker #(
   .COORD_WIDTH(COORD_WIDTH),
   .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
) u_tfn_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_norm_x(rsp_norm_x),
   .rsp_norm_y(rsp_norm_y),
   .rsp_norm_z(rsp_norm_z),
   .rsp_degenerate(rsp_degenerate),
   .csr_ready(csr_ready)
);
